@@ design/lobm_pkg.sv @@
// Shared types and constants for the limit order book matcher.
// Used by lobm_cell and limit_order_book_matcher; no dependencies.
`default_nettype none
package lobm_pkg;

    localparam int BOOK_DEPTH_DEF  = 32;
    localparam int SYMBOL_BITS_DEF = 8;

    localparam logic [5:0] MAX_TRADES = 6'd63;

    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_TRADE = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_MATCH = 1'b1;
    localparam logic SIDE_BID  = 1'b0;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic        side;
        logic [31:0] price;
        logic [31:0] quantity;
        logic [31:0] order_id;
        logic [7:0]  symbol;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  kind;
        logic        status;
        logic [31:0] trade_id;
        logic [31:0] buy_id;
        logic [31:0] sell_id;
        logic [7:0]  trade_symbol;
        logic [31:0] trade_price;
        logic [31:0] trade_quantity;
        logic [5:0]  trade_count;
        logic        last;
    } t_out_word;

    typedef struct packed {
        logic [31:0] price;
        logic [31:0] qty;
        logic [31:0] id;
    } t_order;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_TAKE,
        CELL_SUB
    } t_cell_op;

endpackage
`default_nettype wire

@@ design/lobm_cell.sv @@
// One resting-order slot of a book side; loads, takes its neighbor, or trades down.
// Depends on lobm_pkg.
`default_nettype none
module lobm_cell #(
    parameter int SYMBOL_BITS = lobm_pkg::SYMBOL_BITS_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  lobm_pkg::t_cell_op     i_op,
    input  lobm_pkg::t_order       i_load,
    input  wire [SYMBOL_BITS-1:0]  i_load_sym,
    input  lobm_pkg::t_order       i_nbr,
    input  wire [SYMBOL_BITS-1:0]  i_nbr_sym,
    input  wire                    i_nbr_valid,
    input  wire [31:0]             i_sub,
    output lobm_pkg::t_order       o_ord,
    output logic [SYMBOL_BITS-1:0] o_sym,
    output logic                   o_valid
);
    import lobm_pkg::*;

    t_order                 r_ord;
    logic [SYMBOL_BITS-1:0] r_sym;
    logic                   r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            unique case (i_op)
                CELL_LOAD: r_valid <= 1'b1;
                CELL_TAKE: r_valid <= i_nbr_valid;
                default:   r_valid <= r_valid;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            CELL_LOAD: begin
                r_ord <= i_load;
                r_sym <= i_load_sym;
            end
            CELL_TAKE: begin
                r_ord <= i_nbr;
                r_sym <= i_nbr_sym;
            end
            CELL_SUB: begin
                r_ord.qty <= r_ord.qty - i_sub;
            end
            default: begin
            end
        endcase
    end

    assign o_ord   = r_ord;
    assign o_sym   = r_sym;
    assign o_valid = r_valid;

endmodule
`default_nettype wire

@@ design/limit_order_book_matcher.sv @@
// Top level: bid and ask rows of lobm_cell plus the match sequencer.
// Depends on lobm_pkg and lobm_cell.
//
//  channel | valid       | ready       | word
//  input   | i_in_valid  | o_in_ready  | i_in_word  (t_in_word)
//  output  | o_out_valid | i_out_ready | o_out_word (t_out_word)
//
// Add: result word registered on acceptance.
// Match: each pass is a best-price scan (rows rotate), a bid-order search that
//   makes at most one trade, then compaction of emptied orders; passes repeat
//   while a pass trades. Reset clears valid bits, trade number to one.
// A stalled output holds the sequencer only where it has a trade or done word to send.
`default_nettype none
module limit_order_book_matcher #(
    parameter int BOOK_DEPTH  = lobm_pkg::BOOK_DEPTH_DEF,
    parameter int SYMBOL_BITS = lobm_pkg::SYMBOL_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  lobm_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output lobm_pkg::t_out_word o_out_word
);
    import lobm_pkg::*;

    localparam int STEP_W = $clog2(BOOK_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_CHECK,
        ST_SEARCH,
        ST_COMPACT,
        ST_DONE
    } t_state;

    t_state            r_state;
    logic [STEP_W-1:0] r_step;
    logic [31:0]       r_best_bid;
    logic [31:0]       r_best_ask;
    logic              r_found;
    logic [5:0]        r_trades;
    logic [31:0]       r_trade_num;
    logic              r_ov;
    t_out_word         r_out;
    logic              n_ov;
    t_out_word         n_out;

    t_order                 b_ord [BOOK_DEPTH];
    t_order                 a_ord [BOOK_DEPTH];
    logic [SYMBOL_BITS-1:0] b_sym [BOOK_DEPTH];
    logic [SYMBOL_BITS-1:0] a_sym [BOOK_DEPTH];
    logic [BOOK_DEPTH-1:0]  b_valid, a_valid;
    t_cell_op               b_op [BOOK_DEPTH];
    t_cell_op               a_op [BOOK_DEPTH];
    logic [31:0]            a_sub [BOOK_DEPTH];
    logic [31:0]            b_sub0;

    logic                   out_free, accept, rotate_b, rotate_a, emit, load_out;
    logic [SYMBOL_BITS+7:0] in_sym_ext;
    logic [SYMBOL_BITS-1:0] in_sym;
    logic [SYMBOL_BITS+7:0] tr_sym_ext;
    t_order                 load_ord;
    logic [BOOK_DEPTH-1:0]  b_free1, a_free1, a_hit, a_sel;
    logic [BOOK_DEPTH-1:0]  b_zero, a_zero, b_z1, a_z1, b_ge, a_ge;
    logic                   b_head_hit;
    logic [31:0]            a_sel_qty, a_sel_price, a_sel_id, tr_qty;

    assign out_free   = !r_ov || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && out_free;
    assign accept     = i_in_valid && o_in_ready;

    assign in_sym_ext = {{SYMBOL_BITS{1'b0}}, i_in_word.symbol};
    assign in_sym     = in_sym_ext[SYMBOL_BITS-1:0];
    assign load_ord   = '{price: i_in_word.price, qty: i_in_word.quantity,
                          id: i_in_word.order_id};

    assign b_free1 = ~b_valid & (b_valid + 1'b1);
    assign a_free1 = ~a_valid & (a_valid + 1'b1);

    always_comb begin
        a_sel_qty   = '0;
        a_sel_price = '0;
        a_sel_id    = '0;
        for (int k = 0; k < BOOK_DEPTH; k++) begin
            a_hit[k]  = a_valid[k] && (a_ord[k].price == r_best_ask) && (a_sym[k] == b_sym[0]);
            b_zero[k] = b_valid[k] && (b_ord[k].qty == '0);
            a_zero[k] = a_valid[k] && (a_ord[k].qty == '0);
        end
        a_sel = a_hit & ~(a_hit - 1'b1);
        for (int k = 0; k < BOOK_DEPTH; k++) begin
            if (a_sel[k]) begin
                a_sel_qty   = a_ord[k].qty;
                a_sel_price = a_ord[k].price;
                a_sel_id    = a_ord[k].id;
            end
        end
        b_z1 = b_zero & ~(b_zero - 1'b1);
        a_z1 = a_zero & ~(a_zero - 1'b1);
        b_ge = ~(b_z1 - 1'b1) & {BOOK_DEPTH{|b_zero}};
        a_ge = ~(a_z1 - 1'b1) & {BOOK_DEPTH{|a_zero}};
    end

    assign b_head_hit = b_valid[0] && (b_ord[0].price == r_best_bid);
    assign tr_qty     = (b_ord[0].qty < a_sel_qty) ? b_ord[0].qty : a_sel_qty;
    assign tr_sym_ext = {8'd0, b_sym[0]};
    assign emit       = (r_state == ST_SEARCH) && !r_found && b_head_hit && (|a_hit) && out_free;
    assign rotate_a   = (r_state == ST_SCAN);
    assign rotate_b   = (r_state == ST_SCAN) ||
                        ((r_state == ST_SEARCH) && !emit &&
                         !(!r_found && b_head_hit && (|a_hit)));
    assign b_sub0     = tr_qty;

    assign load_out = (accept && i_in_word.cmd == CMD_ADD) || emit ||
                      ((r_state == ST_DONE) && out_free);
    assign n_ov     = load_out || (r_ov && !i_out_ready);

    always_comb begin
        n_out      = '0;
        n_out.last = 1'b1;
        if (r_state == ST_SEARCH) begin
            n_out.kind           = KIND_TRADE;
            n_out.last           = 1'b0;
            n_out.trade_id       = r_trade_num;
            n_out.buy_id         = b_ord[0].id;
            n_out.sell_id        = a_sel_id;
            n_out.trade_symbol   = tr_sym_ext[7:0];
            n_out.trade_price    = a_sel_price;
            n_out.trade_quantity = tr_qty;
        end else if (r_state == ST_DONE) begin
            n_out.kind        = KIND_DONE;
            n_out.trade_count = r_trades;
        end else begin
            n_out.kind   = KIND_ADD;
            n_out.status = ((i_in_word.side == SIDE_BID) ?
                            b_valid[BOOK_DEPTH-1] : a_valid[BOOK_DEPTH-1])
                           ? STATUS_FULL : STATUS_OK;
        end
    end

    always_comb begin
        for (int k = 0; k < BOOK_DEPTH; k++) begin
            b_op[k]  = CELL_HOLD;
            a_op[k]  = CELL_HOLD;
            a_sub[k] = tr_qty;
            if (accept && i_in_word.cmd == CMD_ADD) begin
                if (i_in_word.side == SIDE_BID && b_free1[k]) b_op[k] = CELL_LOAD;
                if (i_in_word.side != SIDE_BID && a_free1[k]) a_op[k] = CELL_LOAD;
            end
            if (rotate_b) b_op[k] = CELL_TAKE;
            if (rotate_a) a_op[k] = CELL_TAKE;
            if (emit) begin
                if (k == 0) b_op[k] = CELL_SUB;
                if (a_sel[k]) a_op[k] = CELL_SUB;
            end
            if (r_state == ST_COMPACT) begin
                if (b_ge[k]) b_op[k] = CELL_TAKE;
                if (a_ge[k]) a_op[k] = CELL_TAKE;
            end
        end
    end

    for (genvar k = 0; k < BOOK_DEPTH; k++) begin : g_cell
        localparam int NB = (k == BOOK_DEPTH - 1) ? 0 : k + 1;
        logic b_nv, a_nv;
        assign b_nv = (k == BOOK_DEPTH - 1) ? (rotate_b && b_valid[0]) : b_valid[NB];
        assign a_nv = (k == BOOK_DEPTH - 1) ? (rotate_a && a_valid[0]) : a_valid[NB];

        lobm_cell #(.SYMBOL_BITS(SYMBOL_BITS)) u_bid (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_op(b_op[k]),
            .i_load(load_ord), .i_load_sym(in_sym),
            .i_nbr(b_ord[NB]), .i_nbr_sym(b_sym[NB]), .i_nbr_valid(b_nv),
            .i_sub(b_sub0),
            .o_ord(b_ord[k]), .o_sym(b_sym[k]), .o_valid(b_valid[k])
        );
        lobm_cell #(.SYMBOL_BITS(SYMBOL_BITS)) u_ask (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_op(a_op[k]),
            .i_load(load_ord), .i_load_sym(in_sym),
            .i_nbr(a_ord[NB]), .i_nbr_sym(a_sym[NB]), .i_nbr_valid(a_nv),
            .i_sub(a_sub[k]),
            .o_ord(a_ord[k]), .o_sym(a_sym[k]), .o_valid(a_valid[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ov        <= 1'b0;
            r_trade_num <= 32'd1;
            r_step      <= '0;
            r_found     <= 1'b0;
            r_trades    <= '0;
        end else begin
            r_ov <= n_ov;
            if (load_out) r_out <= n_out;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept && i_in_word.cmd != CMD_ADD) begin
                        r_trades <= '0;
                        r_state  <= ST_START;
                    end
                end
                ST_START: begin
                    r_best_bid <= '0;
                    r_best_ask <= '1;
                    r_step     <= '0;
                    if (!b_valid[0] || !a_valid[0] || r_trades == MAX_TRADES) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (b_valid[0] && b_ord[0].price > r_best_bid) r_best_bid <= b_ord[0].price;
                    if (a_valid[0] && a_ord[0].price < r_best_ask) r_best_ask <= a_ord[0].price;
                    if (r_step == STEP_W'(BOOK_DEPTH - 1)) begin
                        r_step  <= '0;
                        r_state <= ST_CHECK;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                ST_CHECK: begin
                    r_found <= 1'b0;
                    r_state <= (r_best_bid < r_best_ask) ? ST_DONE : ST_SEARCH;
                end
                ST_SEARCH: begin
                    if (emit) begin
                        r_found     <= 1'b1;
                        r_trade_num <= r_trade_num + 1'b1;
                        r_trades    <= r_trades + 1'b1;
                    end else if (rotate_b) begin
                        if (r_step == STEP_W'(BOOK_DEPTH - 1)) begin
                            r_step  <= '0;
                            r_state <= ST_COMPACT;
                        end else begin
                            r_step <= r_step + 1'b1;
                        end
                    end
                end
                ST_COMPACT: begin
                    if (!(|b_zero) && !(|a_zero)) begin
                        r_state <= r_found ? ST_START : ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_word  = r_out;

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.kind == KIND_DONE) |-> o_out_word.last)
        else $error("done word without last");

    a_trade_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.kind == KIND_TRADE) |-> !o_out_word.last)
        else $error("trade word marked last");

    a_ready_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (!o_out_valid || i_out_ready))
        else $error("input taken with output blocked");

endmodule
`default_nettype wire
